[rtl/core/rtp_pkg.sv]
// ----------------------------------------------------------------------------
// rtp_pkg: shared types and constants of the ringtone note parser
// Holds result kinds, the note command passed from parser to timing unit
// and the tone frequency table.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam logic [1:0] KIND_TONE = 2'd0;
  localparam logic [1:0] KIND_REST = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // note command from the front parser to the back timing unit
  typedef struct packed {
    logic       end_only;
    logic       is_rest;
    logic       dotted;
    logic       last;
    logic [5:0] tone_idx;
    logic [6:0] length;
    logic [9:0] bpm;
  } note_cmd_t;

  function automatic logic [11:0] tone_hz(input logic [5:0] idx);
    logic [11:0] f;
    case (idx)
      6'd0: f = 12'd262;   6'd1: f = 12'd277;   6'd2: f = 12'd294;
      6'd3: f = 12'd311;   6'd4: f = 12'd330;   6'd5: f = 12'd349;
      6'd6: f = 12'd370;   6'd7: f = 12'd392;   6'd8: f = 12'd415;
      6'd9: f = 12'd440;   6'd10: f = 12'd466;  6'd11: f = 12'd494;
      6'd12: f = 12'd523;  6'd13: f = 12'd554;  6'd14: f = 12'd587;
      6'd15: f = 12'd622;  6'd16: f = 12'd659;  6'd17: f = 12'd698;
      6'd18: f = 12'd740;  6'd19: f = 12'd784;  6'd20: f = 12'd830;
      6'd21: f = 12'd880;  6'd22: f = 12'd932;  6'd23: f = 12'd988;
      6'd24: f = 12'd1047; 6'd25: f = 12'd1109; 6'd26: f = 12'd1175;
      6'd27: f = 12'd1244; 6'd28: f = 12'd1319; 6'd29: f = 12'd1397;
      6'd30: f = 12'd1480; 6'd31: f = 12'd1568; 6'd32: f = 12'd1660;
      6'd33: f = 12'd1760; 6'd34: f = 12'd1865; 6'd35: f = 12'd1976;
      6'd36: f = 12'd2093; 6'd37: f = 12'd2218; 6'd38: f = 12'd2349;
      6'd39: f = 12'd2489; 6'd40: f = 12'd2637; 6'd41: f = 12'd2794;
      6'd42: f = 12'd2960; 6'd43: f = 12'd3136; 6'd44: f = 12'd3320;
      6'd45: f = 12'd3520; 6'd46: f = 12'd3728; 6'd47: f = 12'd3951;
      default: f = 12'd262;
    endcase
    return f;
  endfunction

endpackage

[rtl/core/rtttl_note_parser_top.sv]
// ----------------------------------------------------------------------------
// rtttl_note_parser_top: ringtone text parser
// Parses melody text bytes into tone and rest beats with timing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_char_in carries one text byte a beat.
//   Output channel out_valid/out_stall carries kind, half period, duration
//   and last. A byte that closes a note, or a zero byte, yields one beat.
//   Other bytes are absorbed and yield nothing.
//   A note command goes through a two-entry queue to the timing unit, whose
//   shared divider runs three divisions in turn (NW = 19 quotient bits at the
//   default timer clock); the timing unit takes no new note until its result
//   beat has been taken, and this divider loop sets the rate for such bytes.
//   The parser stalls only when the queue is full; the result is held in
//   a register until the receiver lowers out_stall.
//   Reset (rst_n low, synchronous) returns the parser to skipping the name
//   with defaults d=4, o=6, b=63 and empties the queue.
// ----------------------------------------------------------------------------
module rtttl_note_parser_top #(
  parameter int unsigned TIMER_CLOCK_HZ = 1000000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [10:0] out_half_period_us,
  output logic [18:0] out_duration_ms,
  output logic        out_last
);
  import rtp_pkg::*;

  note_cmd_t f_cmd, q_cmd;
  logic f_valid, q_stall, q_valid, q_take;

  // front parser
  rtp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_char_in(in_char_in), .cmd_valid(f_valid), .cmd_stall(q_stall), .cmd(f_cmd)
  );

  // command queue
  rtp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_stall(q_stall), .wr_cmd(f_cmd),
    .rd_valid(q_valid), .rd_take(q_take), .rd_cmd(q_cmd)
  );

  // timing unit
  rtp_back #(.TIMER_CLOCK_HZ(TIMER_CLOCK_HZ)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_cmd),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_half_period_us(out_half_period_us), .out_duration_ms(out_duration_ms),
    .out_last(out_last)
  );

  // checks
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_TONE || out_kind == KIND_REST ||
                   out_kind == KIND_END)) else $error("bad result kind");
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_END |-> out_last) else $error("end without last");
  a_rest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_TONE |-> out_half_period_us == '0)
    else $error("rest with period");
endmodule

[rtl/core/rtp_front.sv]
// ----------------------------------------------------------------------------
// rtp_front: character parser
// Walks header and note syntax one character a beat and issues a note
// command each time a character closes a note or ends the melody.
// ----------------------------------------------------------------------------
module rtp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_in,
  output logic               cmd_valid,
  input  logic               cmd_stall,
  output rtp_pkg::note_cmd_t cmd
);
  import rtp_pkg::*;

  localparam logic [3:0] PH_NAME = 4'd0, PH_HEADER = 4'd1, PH_KEY = 4'd2,
    PH_VAL1 = 4'd3, PH_VAL2 = 4'd4, PH_IDLE = 4'd5, PH_LEN1 = 4'd6,
    PH_LEN2 = 4'd7, PH_LETTER = 4'd8, PH_SHARP = 4'd9, PH_DOT1 = 4'd10,
    PH_OCT = 4'd11, PH_DONE = 4'd12;
  localparam logic [1:0] KEY_NONE = 2'd0, KEY_D = 2'd1, KEY_O = 2'd2, KEY_B = 2'd3;

  logic [3:0] phase_r, phase_nxt;
  logic [1:0] key_r, key_nxt;
  logic [6:0] dlen_r, dlen_nxt;
  logic [3:0] doct_r, doct_nxt;
  logic [9:0] bpm_r, bpm_nxt;
  logic [6:0] nlen_r, nlen_nxt;
  logic [3:0] semi_r, semi_nxt;
  logic [3:0] noct_r, noct_nxt;
  logic       rest_r, rest_nxt, dot_r, dot_nxt, pend_r, pend_nxt;
  logic       emit, emit_last;

  logic       is_dig;
  logic [3:0] dig;
  logic [7:0] c;
  logic       acc;
  logic [13:0] kv10;
  logic [1:0] oc;
  logic [3:0] semi_cl;
  logic [5:0] idx;

  assign c = in_char_in;
  assign is_dig = (c >= 8'h30) && (c <= 8'h39);
  assign dig = 4'(c - 8'h30);
  assign in_stall = cmd_stall;
  assign acc = in_valid && !cmd_stall;

  always_comb begin
    case (key_r)
      KEY_D:   kv10 = 14'(dlen_r) * 14'd10 + 14'(dig);
      KEY_O:   kv10 = 14'(doct_r) * 14'd10 + 14'(dig);
      default: kv10 = 14'(bpm_r) * 14'd10 + 14'(dig);
    endcase
  end

  // note fields for the command, clamped octave and semitone
  always_comb begin
    if (noct_r < 4'd4) oc = 2'd0;
    else if (noct_r > 4'd7) oc = 2'd3;
    else oc = 2'(noct_r - 4'd4);
    semi_cl = (semi_r > 4'd11) ? 4'd11 : semi_r;
    idx = 6'(oc) * 6'd12 + 6'(semi_cl);
  end

  // parser next state
  always_comb begin
    logic hdr;
    logic [1:0] hkey;
    logic set_val;
    logic [9:0] val;
    logic beg;
    logic let_set;
    hdr = 1'b0; hkey = KEY_NONE; set_val = 1'b0; val = '0;
    beg = 1'b0; let_set = 1'b0;
    phase_nxt = phase_r; key_nxt = key_r; dlen_nxt = dlen_r; doct_nxt = doct_r;
    bpm_nxt = bpm_r; nlen_nxt = nlen_r; semi_nxt = semi_r; noct_nxt = noct_r;
    rest_nxt = rest_r; dot_nxt = dot_r; pend_nxt = pend_r;
    emit = 1'b0; emit_last = 1'b0;
    if (c == 8'h00) begin
      emit = 1'b1; emit_last = 1'b1;
    end else begin
      case (phase_r)
        PH_HEADER: hdr = 1'b1;
        PH_KEY: begin
          if (c == 8'h3d || c == 8'h20) begin
          end else if (is_dig) begin
            set_val = 1'b1; val = 10'(dig); phase_nxt = PH_VAL1;
          end else hdr = 1'b1;
        end
        PH_VAL1: begin
          if (is_dig && key_r != KEY_O) begin
            set_val = 1'b1; val = 10'(kv10); phase_nxt = PH_VAL2;
          end else hdr = 1'b1;
        end
        PH_VAL2: begin
          if (is_dig && key_r == KEY_B) begin
            set_val = 1'b1; val = 10'(kv10); phase_nxt = PH_HEADER;
          end else hdr = 1'b1;
        end
        PH_IDLE: beg = (c != 8'h2c);
        PH_LEN1: begin
          if (is_dig) begin
            nlen_nxt = 7'(14'(nlen_r) * 14'd10 + 14'(dig));
            phase_nxt = PH_LEN2;
          end else let_set = 1'b1;
        end
        PH_LEN2: let_set = 1'b1;
        PH_LETTER, PH_SHARP, PH_DOT1, PH_OCT, PH_DONE: begin
          if (c == 8'h23 && phase_r == PH_LETTER) begin
            if (!rest_r && semi_r < 4'd11) semi_nxt = semi_r + 4'd1;
            phase_nxt = PH_SHARP;
          end else if (c == 8'h2e && phase_r != PH_DONE) begin
            dot_nxt = 1'b1;
            phase_nxt = (phase_r == PH_LETTER || phase_r == PH_SHARP) ? PH_DOT1 : PH_DONE;
          end else if (is_dig && phase_r != PH_OCT && phase_r != PH_DONE) begin
            noct_nxt = dig; phase_nxt = PH_OCT;
          end else begin
            emit = 1'b1; pend_nxt = 1'b0; phase_nxt = PH_IDLE;
            beg = (c != 8'h2c);
          end
        end
        default: phase_nxt = (c == 8'h3a) ? PH_HEADER : PH_NAME;
      endcase
      // header character handling
      if (hdr) begin
        phase_nxt = PH_HEADER;
        if (c == 8'h3a) begin
          key_nxt = KEY_NONE; phase_nxt = PH_IDLE;
        end else if (c == 8'h64 || c == 8'h6f || c == 8'h62) begin
          hkey = (c == 8'h64) ? KEY_D : (c == 8'h6f) ? KEY_O : KEY_B;
          key_nxt = hkey; phase_nxt = PH_KEY;
          case (hkey)
            KEY_D:   dlen_nxt = '0;
            KEY_O:   doct_nxt = '0;
            default: bpm_nxt = '0;
          endcase
        end
      end
      if (set_val) begin
        case (key_r)
          KEY_D:   dlen_nxt = val[6:0];
          KEY_O:   doct_nxt = val[3:0];
          KEY_B:   bpm_nxt = val;
          default: ;
        endcase
      end
      // start of a note
      if (beg) begin
        pend_nxt = 1'b1; noct_nxt = doct_r; dot_nxt = 1'b0;
        rest_nxt = 1'b1; semi_nxt = '0;
        if (is_dig) begin
          nlen_nxt = 7'(dig); phase_nxt = PH_LEN1;
        end else begin
          nlen_nxt = dlen_r; let_set = 1'b1;
        end
      end
      if (let_set) begin
        rest_nxt = 1'b0; phase_nxt = PH_LETTER;
        case (c)
          8'h63: semi_nxt = 4'd0;
          8'h64: semi_nxt = 4'd2;
          8'h65: semi_nxt = 4'd4;
          8'h66: semi_nxt = 4'd5;
          8'h67: semi_nxt = 4'd7;
          8'h61: semi_nxt = 4'd9;
          8'h62: semi_nxt = 4'd11;
          default: begin rest_nxt = 1'b1; semi_nxt = 4'd0; end
        endcase
      end
    end
  end

  // command to the back unit
  always_comb begin
    cmd_valid = in_valid && emit;
    cmd.end_only = emit_last && !pend_r;
    cmd.is_rest = rest_r;
    cmd.dotted = dot_r;
    cmd.last = emit_last;
    cmd.tone_idx = idx;
    cmd.length = nlen_r;
    cmd.bpm = bpm_r;
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n || (acc && c == 8'h00)) begin
      phase_r <= PH_NAME; key_r <= KEY_NONE; dlen_r <= 7'd4; doct_r <= 4'd6;
      bpm_r <= 10'd63; nlen_r <= '0; semi_r <= '0; noct_r <= '0;
      rest_r <= 1'b1; dot_r <= 1'b0; pend_r <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt; key_r <= key_nxt; dlen_r <= dlen_nxt; doct_r <= doct_nxt;
      bpm_r <= bpm_nxt; nlen_r <= nlen_nxt; semi_r <= semi_nxt; noct_r <= noct_nxt;
      rest_r <= rest_nxt; dot_r <= dot_nxt; pend_r <= pend_nxt;
    end
  end
endmodule

[rtl/core/rtp_queue.sv]
// ----------------------------------------------------------------------------
// rtp_queue: two-entry command queue
// Decouples the parser from the timing unit so each side stalls alone.
// ----------------------------------------------------------------------------
module rtp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_stall,
  input  rtp_pkg::note_cmd_t wr_cmd,
  output logic               rd_valid,
  input  logic               rd_take,
  output rtp_pkg::note_cmd_t rd_cmd
);
  import rtp_pkg::*;

  note_cmd_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_cmd = mem_r[rp_r];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_take && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
endmodule

[rtl/core/rtp_back.sv]
// ----------------------------------------------------------------------------
// rtp_back: note timing unit
// One shared restoring divider works out tempo, length and tone divisions
// in turn, then the result beat is held until taken.
// ----------------------------------------------------------------------------
module rtp_back #(
  parameter int unsigned TIMER_CLOCK_HZ = 1000000
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  rtp_pkg::note_cmd_t cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [10:0]        out_half_period_us,
  output logic [18:0]        out_duration_ms,
  output logic               out_last
);
  import rtp_pkg::*;

  localparam int unsigned HALF_CLK = TIMER_CLOCK_HZ / 2;
  localparam int NW = $clog2(HALF_CLK + 1) > 16 ? $clog2(HALF_CLK + 1) : 16;
  localparam int CW = $clog2(NW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0, ST_DIV1 = 3'd1, ST_DIV2 = 3'd2,
    ST_DIV3 = 3'd3, ST_OUT = 3'd4;

  logic [2:0]    st_r;
  note_cmd_t     c_r;
  logic [NW-1:0] quo_r, num_r;
  logic [11:0]   den_r;
  logic [12:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic [18:0]   dur_r;
  logic [12:0]   trial;
  logic [NW-1:0] half_full;

  assign cmd_take = (st_r == ST_IDLE) && cmd_valid;
  assign out_valid = (st_r == ST_OUT);
  assign trial = {rem_r[11:0], num_r[NW-1]} - {1'b0, den_r};
  assign half_full = {quo_r[NW-2:0], !trial[12]};

  // sequencer with one shift-subtract division step per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      case (st_r)
        ST_IDLE: if (cmd_valid) begin
          c_r <= cmd;
          st_r <= ST_DIV1;
          num_r <= NW'(60000);
          den_r <= {2'b0, cmd.bpm};
          rem_r <= '0; quo_r <= '0; cnt_r <= CW'(NW);
        end
        ST_DIV1, ST_DIV2, ST_DIV3: begin
          if (cnt_r != CW'(1)) begin
            num_r <= {num_r[NW-2:0], 1'b0};
            quo_r <= half_full;
            rem_r <= trial[12] ? {rem_r[11:0], num_r[NW-1]} : trial;
            cnt_r <= cnt_r - CW'(1);
          end else begin
            rem_r <= '0; cnt_r <= CW'(NW);
            if (st_r == ST_DIV1) begin
              quo_r <= '0;
              num_r <= half_full;
              den_r <= {5'b0, c_r.length};
              st_r <= ST_DIV2;
            end else if (st_r == ST_DIV2) begin
              quo_r <= '0;
              if (c_r.bpm == '0 || c_r.length == '0) dur_r <= '0;
              else if (c_r.dotted) dur_r <= 19'((21'(half_full) * 21'd12) >> 1);
              else dur_r <= 19'(21'(half_full) * 21'd4);
              num_r <= NW'(HALF_CLK);
              den_r <= tone_hz(c_r.tone_idx);
              st_r <= ST_DIV3;
            end else begin
              quo_r <= half_full;
              st_r <= ST_OUT;
            end
          end
        end
        ST_OUT: if (!out_stall) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // result beat
  always_comb begin
    out_last = c_r.last;
    if (c_r.end_only) begin
      out_kind = KIND_END; out_half_period_us = '0; out_duration_ms = '0;
    end else begin
      out_kind = c_r.is_rest ? KIND_REST : KIND_TONE;
      out_duration_ms = dur_r;
      if (c_r.is_rest) out_half_period_us = '0;
      else if (quo_r > NW'(2047)) out_half_period_us = 11'd2047;
      else out_half_period_us = 11'(quo_r);
    end
  end
endmodule

[verif/rtttl_note_parser_checker.sv]
// ----------------------------------------------------------------------------
// rtttl_note_parser_checker: scoreboard of the ringtone note parser
// Watches both channels, predicts each result from the accepted text bytes
// and compares every accepted result beat field by field.
// ----------------------------------------------------------------------------
module rtttl_note_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [10:0] out_half_period_us,
  input  logic [18:0] out_duration_ms,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_count,
  output int          note_count,
  output int          end_count
);
  import rtp_pkg::*;

  typedef enum logic [3:0] {
    PH_NAME, PH_HEADER, PH_KEY, PH_VAL1, PH_VAL2, PH_IDLE, PH_LEN1, PH_LEN2,
    PH_LETTER, PH_SHARP, PH_DOT1, PH_OCT, PH_DONE
  } phase_e;
  typedef enum logic [1:0] {HK_NONE, HK_D, HK_O, HK_B} hkey_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] half;
    logic [18:0] dur;
    logic        last;
  } beat_t;

  localparam int unsigned HZ_TIMER = 1000000;

  beat_t  expected_beats[$];
  phase_e phase;
  hkey_e  hkey;
  logic [6:0] dflt_len;
  logic [3:0] dflt_oct;
  logic [9:0] bpm;
  logic [6:0] n_len;
  logic [3:0] n_semi;
  logic [3:0] n_oct;
  logic n_rest, n_dot, n_pend;

  function automatic logic [11:0] freq_of(input int idx);
    int t[48] = '{262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
      523, 554, 587, 622, 659, 698, 740, 784, 830, 880, 932, 988,
      1047, 1109, 1175, 1244, 1319, 1397, 1480, 1568, 1660, 1760, 1865, 1976,
      2093, 2218, 2349, 2489, 2637, 2794, 2960, 3136, 3320, 3520, 3728, 3951};
    return t[idx];
  endfunction

  task automatic clear_parser();
    phase = PH_NAME; hkey = HK_NONE; dflt_len = 4; dflt_oct = 6; bpm = 63;
    n_len = 0; n_semi = 0; n_oct = 0; n_rest = 1; n_dot = 0; n_pend = 0;
  endtask

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int unsigned held_value();
    if (hkey == HK_D) return dflt_len;
    if (hkey == HK_O) return dflt_oct;
    return bpm;
  endfunction

  task automatic store_value(input int unsigned v);
    if (hkey == HK_D) dflt_len = v[6:0];
    else if (hkey == HK_O) dflt_oct = v[3:0];
    else if (hkey == HK_B) bpm = v[9:0];
  endtask

  task automatic header_byte(input logic [7:0] c);
    phase = PH_HEADER;
    if (c == ":") begin
      hkey = HK_NONE; phase = PH_IDLE;
    end else if (c == "d" || c == "o" || c == "b") begin
      hkey = (c == "d") ? HK_D : (c == "o") ? HK_O : HK_B;
      store_value(0);
      phase = PH_KEY;
    end
  endtask

  task automatic take_letter(input logic [7:0] c);
    n_rest = 0;
    case (c)
      "c": n_semi = 0;
      "d": n_semi = 2;
      "e": n_semi = 4;
      "f": n_semi = 5;
      "g": n_semi = 7;
      "a": n_semi = 9;
      "b": n_semi = 11;
      default: begin
        n_rest = 1; n_semi = 0;
      end
    endcase
    phase = PH_LETTER;
  endtask

  task automatic open_note(input logic [7:0] c);
    n_pend = 1; n_oct = dflt_oct; n_dot = 0; n_rest = 1; n_semi = 0;
    if (is_num(c)) begin
      n_len = c - "0"; phase = PH_LEN1;
    end else begin
      n_len = dflt_len; take_letter(c);
    end
  endtask

  function automatic beat_t note_beat(input bit last);
    beat_t b;
    int unsigned d, h, o;
    d = 0; h = 0;
    if (bpm != 0 && n_len != 0) begin
      d = ((60000 / bpm) / n_len) * 4;
      if (n_dot) d = (d * 3) / 2;
    end
    if (!n_rest) begin
      o = n_oct < 4 ? 4 : (n_oct > 7 ? 7 : n_oct);
      h = (HZ_TIMER / freq_of(((o - 4) * 12 + (n_semi > 11 ? 11 : n_semi)) % 48)) / 2;
      if (h > 2047) h = 2047;
    end
    b.kind = n_rest ? KIND_REST : KIND_TONE;
    b.half = h[10:0];
    b.dur = d[18:0];
    b.last = last;
    return b;
  endfunction

  // advance the parser model by one text byte
  task automatic parse_byte(input logic [7:0] c);
    beat_t b;
    logic [7:0] dg;
    dg = c - "0";
    if (c == 0) begin
      if (n_pend) b = note_beat(1);
      else b = '{kind: KIND_END, half: 0, dur: 0, last: 1};
      expected_beats.push_back(b);
      clear_parser();
      return;
    end
    case (phase)
      PH_HEADER: header_byte(c);
      PH_KEY:
        if (c == "=" || c == " ") ;
        else if (is_num(c)) begin
          store_value(dg); phase = PH_VAL1;
        end else header_byte(c);
      PH_VAL1:
        if (is_num(c) && hkey != HK_O) begin
          store_value(held_value() * 10 + dg); phase = PH_VAL2;
        end else header_byte(c);
      PH_VAL2:
        if (is_num(c) && hkey == HK_B) begin
          store_value(held_value() * 10 + dg); phase = PH_HEADER;
        end else header_byte(c);
      PH_IDLE: if (c != ",") open_note(c);
      PH_LEN1:
        if (is_num(c)) begin
          n_len = 7'((n_len * 10 + dg) & 8'h7f); phase = PH_LEN2;
        end else take_letter(c);
      PH_LEN2: take_letter(c);
      PH_LETTER, PH_SHARP, PH_DOT1, PH_OCT, PH_DONE:
        if (c == "#" && phase == PH_LETTER) begin
          if (!n_rest && n_semi < 11) n_semi++;
          phase = PH_SHARP;
        end else if (c == "." && phase != PH_DONE) begin
          n_dot = 1;
          phase = (phase == PH_LETTER || phase == PH_SHARP) ? PH_DOT1 : PH_DONE;
        end else if (is_num(c) && phase != PH_OCT && phase != PH_DONE) begin
          n_oct = dg[3:0]; phase = PH_OCT;
        end else begin
          expected_beats.push_back(note_beat(0));
          n_pend = 0; phase = PH_IDLE;
          if (c != ",") open_note(c);
        end
      default: phase = (c == ":") ? PH_HEADER : PH_NAME;
    endcase
  endtask

  assign pending_count = expected_beats.size();

  initial begin
    fail_count = 0; note_count = 0; end_count = 0;
    clear_parser();
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat kind=%0d half=%0d dur=%0d last=%0d",
                   out_kind, out_half_period_us, out_duration_ms, out_last);
      end else begin
        want = expected_beats.pop_front();
        if (out_kind == KIND_END) end_count++;
        else note_count++;
        if (want.kind !== out_kind || want.half !== out_half_period_us ||
            want.dur !== out_duration_ms || want.last !== out_last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: want kind=%0d half=%0d dur=%0d last=%0d, got %0d %0d %0d %0d",
                     want.kind, want.half, want.dur, want.last, out_kind,
                     out_half_period_us, out_duration_ms, out_last);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) parse_byte(in_char_in);
  end

endmodule

[verif/tb_rtttl_note_parser_top.sv]
// ----------------------------------------------------------------------------
// tb_rtttl_note_parser_top: testbench of the ringtone note parser
// Feeds directed and random melody text through the parser under several
// idle and stall patterns; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_rtttl_note_parser_top;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_in;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [10:0] out_half_period_us;
  logic [18:0] out_duration_ms;
  logic        out_last;
  int          fail_count, pending_count, note_count, end_count;
  int          idle_pct, stall_pct, quiet_cycles, byte_count;
  bit          timed_out;

  localparam int WATCHDOG = 20000;

  rtttl_note_parser_top i_dut (.*);

  rtttl_note_parser_checker i_checker (.*);

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver stall pattern
  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired, %0d beats still expected", pending_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // send one text byte, idling first at random; valid stays up afterwards
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    byte_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic string digits(input int n);
    string s;
    s = "";
    repeat (n) s = {s, string'(pick("0123456789"))};
    return s;
  endfunction

  // one well-formed melody with random content, sometimes broken up
  task automatic send_melody();
    string s;
    int notes;
    s = {"tn", ":"};
    if ($urandom_range(3) != 0) s = {s, "d=", digits($urandom_range(1, 2)), ","};
    if ($urandom_range(3) != 0) s = {s, "o=", digits(1), ","};
    if ($urandom_range(3) != 0) s = {s, "b=", digits($urandom_range(1, 3)), ","};
    s = {s, ":"};
    notes = $urandom_range(1, 8);
    for (int n = 0; n < notes; n++) begin
      if ($urandom_range(2) == 0) s = {s, digits($urandom_range(1, 2))};
      s = {s, string'(pick("abcdefgpabcdefgx,"))};
      if ($urandom_range(2) == 0) s = {s, "#"};
      if ($urandom_range(3) == 0) s = {s, "."};
      if ($urandom_range(1) == 0) s = {s, digits(1)};
      if ($urandom_range(5) == 0) s = {s, "."};
      if ($urandom_range(4) != 0) s = {s, ","};
      if ($urandom_range(15) == 0) s = {s, string'(8'($urandom_range(1, 255)))};
    end
    send_text(s);
    send_byte(8'd0);
  endtask

  task automatic run_phase(input int idle_p, input int stall_p, input int nbytes);
    int target;
    idle_pct = idle_p;
    stall_pct = stall_p;
    target = byte_count + nbytes;
    while (byte_count < target) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 30)) send_byte(8'($urandom_range(1, 255)));
        send_byte(8'd0);
      end else send_melody();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_in = 8'd0;
    out_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    byte_count = 0;
    timed_out = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: end with no note, defaults, extremes, sharps, dots, octaves
    send_byte(8'd0);
    send_text(":d=64,o=9,b=999:32b#.9,");
    send_byte(8'd255);
    send_byte(8'd0);
    send_text("x:zd=0b=0:4e#3.c");
    send_byte(8'd0);
    send_text("q:b=300:12,99xp#.");
    send_byte(8'd0);

    run_phase(0, 0, 450);
    run_phase(54, 0, 420);
    run_phase(0, 54, 420);
    run_phase(16, 16, 420);
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d text bytes, checked %0d note beats and %0d end beats",
             byte_count, note_count, end_count);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
rtl/core/rtp_pkg.sv
rtl/core/rtp_front.sv
rtl/core/rtp_queue.sv
rtl/core/rtp_back.sv
rtl/core/rtttl_note_parser_top.sv
verif/rtttl_note_parser_checker.sv
verif/tb_rtttl_note_parser_top.sv
